// ===== src/ght_pkg.sv =====
package ght_pkg;

	// table geometry
	localparam int SLOT_COUNT        = 64;
	localparam int SLOT_IDX_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int HANDLE_IDX_W      = 8;
	localparam int GEN_W             = 32 - HANDLE_IDX_W;
	localparam int COUNT_W           = 7;

	typedef enum logic [1:0] {
		MODE_CREATE  = 2'd0,
		MODE_DEREF   = 2'd1,
		MODE_DESTROY = 2'd2,
		MODE_SWEEP   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_ARG = 3'd1,
		ST_FULL    = 3'd2,
		ST_INVALID = 3'd3,
		ST_NONE    = 3'd4
	} status_t;

	// request transaction
	typedef struct packed {
		mode_t       mode;
		logic [31:0] handle;
		logic [7:0]  type_id;
		logic [31:0] object_ref;
		logic [7:0]  owner;
	} cmd_t;

	// result transaction
	typedef struct packed {
		status_t              status;
		logic [31:0]          handle_out;
		logic [31:0]          ref_out;
		logic [7:0]           type_out;
		logic [COUNT_W-1:0]   released_count;
		logic                 last;
	} res_t;

	// slot store write port
	typedef struct packed {
		logic                  create;
		logic                  free;
		logic [SLOT_IDX_W-1:0] addr;
		logic [7:0]            type_id;
		logic [31:0]           object_ref;
		logic [7:0]            owner;
		logic [GEN_W-1:0]      gen;
	} ght_wr_t;

	// slot store registered read data
	typedef struct packed {
		logic             live;
		logic [7:0]       type_id;
		logic [31:0]      object_ref;
		logic [7:0]       owner;
		logic [GEN_W-1:0] gen;
	} ght_rd_t;

endpackage

// ===== src/ght_slot_store.sv =====
module ght_slot_store
	import ght_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [SLOT_IDX_W-1:0] rd_addr,
	output ght_rd_t               rd,
	input  ght_wr_t               wr,
	output logic [SLOT_IDX_W-1:0] free_idx,
	output logic                  full
);

	logic [7:0]       type_mem  [SLOT_COUNT];
	logic [31:0]      ref_mem   [SLOT_COUNT];
	logic [7:0]       owner_mem [SLOT_COUNT];
	logic [GEN_W-1:0] gen_mem   [SLOT_COUNT];

	// live flag per slot; gen_set_q marks a generation written since reset
	logic [SLOT_COUNT-1:0] live_q;
	logic [SLOT_COUNT-1:0] gen_set_q;

	logic             rd_gen_set_q;
	ght_rd_t          rd_q;
	logic [SLOT_COUNT-1:0] free_vec;
	logic [SLOT_COUNT-1:0] first_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			gen_set_q <= '0;
		end else begin
			if (wr.create) begin
				live_q[wr.addr] <= 1'b1;
			end
			if (wr.free) begin
				live_q[wr.addr]    <= 1'b0;
				gen_set_q[wr.addr] <= 1'b1;
			end
		end
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (wr.create) begin
			type_mem[wr.addr]  <= wr.type_id;
			ref_mem[wr.addr]   <= wr.object_ref;
			owner_mem[wr.addr] <= wr.owner;
		end
		if (wr.free) begin
			gen_mem[wr.addr] <= wr.gen;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= '{live:       live_q[rd_addr],
			          type_id:    type_mem[rd_addr],
			          object_ref: ref_mem[rd_addr],
			          owner:      owner_mem[rd_addr],
			          gen:        gen_mem[rd_addr]};
			rd_gen_set_q <= gen_set_q[rd_addr];
		end
	end

	// an unwritten generation reads as one
	assign rd = '{live:       rd_q.live,
	              type_id:    rd_q.type_id,
	              object_ref: rd_q.object_ref,
	              owner:      rd_q.owner,
	              gen:        rd_gen_set_q ? rd_q.gen : GEN_W'(1)};

	// lowest free slot: isolate lowest set bit, then encode
	assign free_vec   = ~live_q;
	assign first_free = free_vec & (~free_vec + SLOT_COUNT'(1));
	assign full       = (free_vec == '0);

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (first_free[i]) begin
				free_idx = free_idx | SLOT_IDX_W'(i);
			end
		end
	end

endmodule

// ===== src/generational_handle_table_top.sv =====
// Generational handle table.
// Request channel: present cmd with start high; it is taken at a rising edge
// where busy is low. busy stays high until the cycle that shows the last
// result of that request. Result channel: res is valid for exactly one cycle
// while res_valid is high; the receiver cannot stall, so it must take every result.
// Create, dereference and destroy give one result, shown after the request has
// passed the address, read and evaluate steps, and the next request can be taken
// in the same cycle as that result. The steps follow from the single registered
// read port of the slot store.
// An owner sweep reads the slots one per cycle through that same port; released
// slots come out in ascending order, one result per cycle at most, with last on
// the final one (or a single "none released" result).
// Reset frees every slot and sets every generation to one at once; no
// clearing pass follows, the block is ready in the first cycle after reset.
module generational_handle_table_top
	import ght_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic res_valid,
	output res_t res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_SWEEP,
		S_FLUSH
	} state_t;

	localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(SLOT_COUNT - 1);

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [SLOT_IDX_W-1:0] idx_q;
	logic                  full_q;
	logic                  pend_q;
	logic [31:0]           pend_ref_q;
	logic [7:0]            pend_type_q;
	logic [COUNT_W-1:0]    cnt_q;

	logic                  rd_en;
	logic [SLOT_IDX_W-1:0] rd_addr;
	ght_rd_t               rd;
	ght_wr_t               wr;
	logic [SLOT_IDX_W-1:0] free_idx;
	logic                  full;

	logic                  args_ok;
	logic                  in_range;
	logic                  hit;
	logic                  owner_match;
	logic [GEN_W-1:0]      gen_inc;
	logic [GEN_W-1:0]      gen_next;
	logic [SLOT_IDX_W-1:0] look_idx;
	logic                  res_fire;
	res_t                  res_d;

	ght_slot_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd       (rd),
		.wr       (wr),
		.free_idx (free_idx),
		.full     (full)
	);

	assign busy = (state_q != S_IDLE);

	// request decode
	assign args_ok  = (cmd_q.type_id != 8'd0) && (cmd_q.object_ref != 32'd0);
	assign in_range = ({1'b0, cmd_q.handle[HANDLE_IDX_W-1:0]}
		< (HANDLE_IDX_W+1)'(SLOT_COUNT));
	assign hit = (cmd_q.type_id != 8'd0) && in_range && rd.live
		&& (rd.type_id == cmd_q.type_id)
		&& (rd.gen == cmd_q.handle[31:HANDLE_IDX_W]);
	assign owner_match = rd.live && (rd.owner == cmd_q.owner);

	// generation advance, skipping zero on wrap
	assign gen_inc  = rd.gen + GEN_W'(1);
	assign gen_next = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

	// slot address for the first read of a request
	always_comb begin
		case (cmd_q.mode)
			MODE_CREATE: look_idx = free_idx;
			MODE_SWEEP:  look_idx = '0;
			default:     look_idx = cmd_q.handle[SLOT_IDX_W-1:0];
		endcase
	end

	// read port: one lookup, or the sweep running one slot ahead
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = look_idx;
		if (state_q == S_READ) begin
			rd_en = 1'b1;
		end else if (state_q == S_SWEEP) begin
			rd_en   = (idx_q != LAST_IDX);
			rd_addr = idx_q + SLOT_IDX_W'(1);
		end
	end

	// write port
	always_comb begin
		wr            = '0;
		wr.addr       = idx_q;
		wr.type_id    = cmd_q.type_id;
		wr.object_ref = cmd_q.object_ref;
		wr.owner      = cmd_q.owner;
		wr.gen        = gen_next;
		if (state_q == S_EVAL) begin
			wr.create = (cmd_q.mode == MODE_CREATE) && args_ok && !full_q;
			wr.free   = (cmd_q.mode == MODE_DESTROY) && hit;
		end else if (state_q == S_SWEEP) begin
			wr.free = owner_match;
		end
	end

	// next result and when it goes out
	assign res_fire = (state_q == S_EVAL) || (state_q == S_FLUSH)
		|| ((state_q == S_SWEEP) && owner_match && pend_q);

	always_comb begin
		res_d      = '0;
		res_d.last = 1'b1;
		if (state_q == S_SWEEP) begin
			// a match pushes out the previous release, which is not last
			res_d.status         = ST_OK;
			res_d.ref_out        = pend_ref_q;
			res_d.type_out       = pend_type_q;
			res_d.released_count = cnt_q;
			res_d.last           = 1'b0;
		end else if (state_q == S_FLUSH) begin
			if (pend_q) begin
				res_d.status         = ST_OK;
				res_d.ref_out        = pend_ref_q;
				res_d.type_out       = pend_type_q;
				res_d.released_count = cnt_q;
			end else begin
				res_d.status = ST_NONE;
			end
		end else if (cmd_q.mode == MODE_CREATE) begin
			if (!args_ok) begin
				res_d.status = ST_BAD_ARG;
			end else if (full_q) begin
				res_d.status = ST_FULL;
			end else begin
				res_d.status     = ST_OK;
				res_d.handle_out = {rd.gen, HANDLE_IDX_W'(idx_q)};
			end
		end else if (!hit) begin
			res_d.status = ST_INVALID;
		end else begin
			res_d.status  = ST_OK;
			res_d.ref_out = rd.object_ref;
			if (cmd_q.mode == MODE_DESTROY) begin
				res_d.type_out = rd.type_id;
			end
		end
	end

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid   <= 1'b0;
			res         <= '0;
			cmd_q       <= '0;
			idx_q       <= '0;
			full_q      <= 1'b0;
			pend_q      <= 1'b0;
			pend_ref_q  <= '0;
			pend_type_q <= '0;
			cnt_q       <= '0;
		end else begin
			res_valid <= res_fire;
			if (res_fire) begin
				res <= res_d;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					idx_q   <= look_idx;
					full_q  <= full;
					pend_q  <= 1'b0;
					cnt_q   <= '0;
					state_q <= (cmd_q.mode == MODE_SWEEP) ? S_SWEEP : S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					// hold the newest release until the next match or the end
					if (owner_match) begin
						pend_q      <= 1'b1;
						pend_ref_q  <= rd.object_ref;
						pend_type_q <= rd.type_id;
						cnt_q       <= cnt_q + COUNT_W'(1);
					end
					if (idx_q == LAST_IDX) begin
						state_q <= S_FLUSH;
					end else begin
						idx_q <= idx_q + SLOT_IDX_W'(1);
					end
				end
				S_FLUSH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// the final result of a request frees the block
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> !busy)
		else $error("last result shown while still busy");

	// intermediate sweep results only while the sweep runs
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> busy)
		else $error("non-final result outside a sweep");

	// an accepted request holds the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	// any error status ends the request
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_OK |-> res.last)
		else $error("error status on a non-final result");

	// an intermediate sweep result trails the running count by the held release
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> res.released_count + COUNT_W'(1) == cnt_q)
		else $error("released count out of step");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

	import ght_pkg::*;

	localparam int ITEMS  = 420;
	// two copies of the slot table: one steers stimulus, one predicts results
	localparam int PLAN   = 0;
	localparam int MIRROR = 1;

	typedef struct {
		cmd_t c;
		bit   hold;	// wait for the table to go quiet before presenting
	} plan_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic res_valid;
	res_t res;

	generational_handle_table_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res      (res)
	);

	// slot table copies
	bit [7:0]       slot_type_m  [0:1][0:SLOT_COUNT-1];
	bit [31:0]      slot_ref_m   [0:1][0:SLOT_COUNT-1];
	bit [GEN_W-1:0] slot_gen_m   [0:1][0:SLOT_COUNT-1];
	bit [7:0]       slot_owner_m [0:1][0:SLOT_COUNT-1];

	res_t       step_out[$];
	res_t       results_due[$];
	plan_item_t cmd_backlog[$];

	logic took = 1'b0;
	int   burst_left = 1;
	int   gap_left = 0;
	int   issued = 0;
	int   errors = 0;
	int   results_checked = 0;
	int   max_released = 0;
	int   mode_seen [0:3];
	int   status_seen [0:7];

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		#3000000;
		$display("timeout with %0d results outstanding", results_due.size());
		$display("FAILED: results differ");
		$finish;
	end

	// generation advance: wraps past all ones to 1, never 0
	function automatic bit [GEN_W-1:0] gen_next(input bit [GEN_W-1:0] g);
		return (g == '1) ? GEN_W'(1) : g + 1'b1;
	endfunction

	// apply one request to table copy cp; results land in step_out
	function automatic void table_step(input int cp, input cmd_t c);
		res_t r;
		int i;
		int idx;
		int n;
		bit hit;
		step_out.delete();
		r = '0;
		r.last = 1'b1;
		case (c.mode)
			MODE_CREATE: begin
				if (c.type_id == 0 || c.object_ref == 0) begin
					r.status = ST_BAD_ARG;
				end else begin
					r.status = ST_FULL;
					hit = 1'b0;
					for (i = 0; i < SLOT_COUNT && !hit; i++) begin
						if (slot_type_m[cp][i] == 0) begin
							slot_type_m[cp][i]  = c.type_id;
							slot_ref_m[cp][i]   = c.object_ref;
							slot_owner_m[cp][i] = c.owner;
							r.status     = ST_OK;
							r.handle_out = {slot_gen_m[cp][i], 8'(i)};
							hit = 1'b1;
						end
					end
				end
				step_out.push_back(r);
			end
			MODE_DEREF, MODE_DESTROY: begin
				idx = int'(c.handle[7:0]);
				if (c.type_id == 0 || idx >= SLOT_COUNT ||
				    slot_type_m[cp][idx] != c.type_id ||
				    slot_gen_m[cp][idx] != c.handle[31:8]) begin
					r.status = ST_INVALID;
				end else begin
					r.status  = ST_OK;
					r.ref_out = slot_ref_m[cp][idx];
					if (c.mode == MODE_DESTROY) begin
						r.type_out = slot_type_m[cp][idx];
						slot_type_m[cp][idx] = '0;
						slot_ref_m[cp][idx]  = '0;
						slot_gen_m[cp][idx]  = gen_next(slot_gen_m[cp][idx]);
					end
				end
				step_out.push_back(r);
			end
			default: begin
				// owner sweep, ascending slot order
				n = 0;
				for (i = 0; i < SLOT_COUNT; i++) begin
					if (slot_type_m[cp][i] != 0 && slot_owner_m[cp][i] == c.owner) begin
						r = '0;
						r.status         = ST_OK;
						r.ref_out        = slot_ref_m[cp][i];
						r.type_out       = slot_type_m[cp][i];
						r.released_count = COUNT_W'(n + 1);
						step_out.push_back(r);
						n++;
						slot_type_m[cp][i] = '0;
						slot_ref_m[cp][i]  = '0;
						slot_gen_m[cp][i]  = gen_next(slot_gen_m[cp][i]);
					end
				end
				if (n == 0) begin
					r = '0;
					r.status = ST_NONE;
				end else begin
					r = step_out.pop_back();
				end
				r.last = 1'b1;
				step_out.push_back(r);
			end
		endcase
	endfunction

	function automatic cmd_t mk(input mode_t m, input logic [31:0] h, input logic [7:0] t,
	                            input logic [31:0] r, input logic [7:0] o);
		cmd_t c;
		c.mode       = m;
		c.handle     = h;
		c.type_id    = t;
		c.object_ref = r;
		c.owner      = o;
		return c;
	endfunction

	// queue one transaction and advance the planning copy
	task automatic send(input cmd_t c, input bit hold);
		plan_item_t it;
		table_step(PLAN, c);
		it.c    = c;
		it.hold = hold;
		cmd_backlog.push_back(it);
		issued++;
	endtask

	// mostly a few owners so sweeps find work
	function automatic logic [7:0] pick_owner();
		return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
	endfunction

	// deref or destroy a live handle, sometimes damaged
	task automatic touch_live(input mode_t m);
		int live[$];
		int i;
		logic [31:0] h;
		logic [7:0] t;
		for (i = 0; i < SLOT_COUNT; i++)
			if (slot_type_m[PLAN][i] != 0) live.push_back(i);
		if (live.size() == 0) begin
			h = $urandom;
			t = 8'($urandom);
		end else begin
			i = live[$urandom_range(0, live.size() - 1)];
			h = {slot_gen_m[PLAN][i], 8'(i)};
			t = slot_type_m[PLAN][i];
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 3))
					0: h[31:8] = h[31:8] - 1'b1;
					1: t = t ^ 8'($urandom_range(1, 255));
					2: h[7:0] = h[7:0] + 8'(SLOT_COUNT);
					default: h[$urandom_range(0, 31)] = ~h[$urandom_range(0, 31)];
				endcase
			end
		end
		send(mk(m, h, t, $urandom, 8'($urandom)), $urandom_range(0, 39) == 0);
	endtask

	// empty the table, fill it with one owner past full, deref and destroy a live handle, then sweep that owner
	task automatic fill_episode(input logic [7:0] own);
		int i;
		logic [31:0] r;
		for (i = 0; i < SLOT_COUNT; i++)
			if (slot_type_m[PLAN][i] != 0)
				send(mk(MODE_SWEEP, $urandom, 8'($urandom), $urandom,
				        slot_owner_m[PLAN][i]), 1'b0);
		for (i = 0; i < SLOT_COUNT + 2; i++) begin
			r = $urandom;
			if (r == 0) r = 1;
			send(mk(MODE_CREATE, $urandom, 8'($urandom_range(1, 255)), r, own), 1'b0);
		end
		touch_live(MODE_DEREF);
		touch_live(MODE_DESTROY);
		send(mk(MODE_SWEEP, $urandom, 8'($urandom), $urandom, own), 1'b0);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("MISMATCH @%0t %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic check_result(input res_t got, input res_t want);
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.handle_out !== want.handle_out)
			report_mismatch("handle_out", got.handle_out, want.handle_out);
		if (got.ref_out !== want.ref_out)
			report_mismatch("ref_out", got.ref_out, want.ref_out);
		if (got.type_out !== want.type_out)
			report_mismatch("type_out", 32'(got.type_out), 32'(want.type_out));
		if (got.released_count !== want.released_count)
			report_mismatch("released_count", 32'(got.released_count),
			                32'(want.released_count));
		if (got.last !== want.last)
			report_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	// request driver: bursts and gaps, junk on cmd while start is low
	always @(negedge clk) begin : drive
		logic [95:0] noise;
		plan_item_t it;
		noise = {$urandom, $urandom, $urandom};
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// transaction still waiting for busy to drop
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
			cmd   <= noise[$bits(cmd_t)-1:0];
		end else if (cmd_backlog.size() == 0 ||
		             (cmd_backlog[0].hold && (results_due.size() != 0 || busy))) begin
			start <= 1'b0;
			cmd   <= noise[$bits(cmd_t)-1:0];
		end else begin
			it = cmd_backlog.pop_front();
			cmd   <= it.c;
			start <= 1'b1;
			if (burst_left > 1) begin
				burst_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				// long stretch with no idle cycles
				burst_left = $urandom_range(20, 60);
				gap_left   = 0;
			end else begin
				burst_left = $urandom_range(1, 8);
				gap_left   = $urandom_range(0, 12);
			end
		end
	end

	// acceptance, prediction and result checking
	always @(posedge clk) begin : observe
		res_t want;
		int k;
		if (arst_n) begin
			if (start && !busy) begin
				table_step(MIRROR, cmd);
				mode_seen[cmd.mode]++;
				for (k = 0; k < step_out.size(); k++) begin
					results_due.push_back(step_out[k]);
					status_seen[step_out[k].status]++;
					if (int'(step_out[k].released_count) > max_released)
						max_released = int'(step_out[k].released_count);
				end
				took <= 1'b1;
			end else begin
				took <= 1'b0;
			end
			if (res_valid) begin
				if (results_due.size() == 0) begin
					report_mismatch("result with nothing pending, status",
					                32'(res.status), 32'd0);
				end else begin
					want = results_due.pop_front();
					check_result(res, want);
					results_checked++;
				end
			end
		end
	end

	initial begin : run
		int i;
		int roll;
		bit ep_a;
		bit ep_b;
		logic [31:0] r;
		for (i = 0; i < SLOT_COUNT; i++) begin
			slot_gen_m[PLAN][i]   = GEN_W'(1);
			slot_gen_m[MIRROR][i] = GEN_W'(1);
		end
		for (i = 0; i < 4; i++) mode_seen[i] = 0;
		for (i = 0; i < 8; i++) status_seen[i] = 0;

		// directed: empty table, bad arguments, extremes, stale handles, sweeps
		send(mk(MODE_DEREF,   32'h0000_0100, 8'h01, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_CREATE,  32'h0, 8'h00, 32'h0000_0005, 8'h00), 1'b0);
		send(mk(MODE_CREATE,  32'h0, 8'h03, 32'h0000_0000, 8'h00), 1'b0);
		send(mk(MODE_CREATE,  32'h0, 8'hFF, 32'hFFFF_FFFF, 8'hFF), 1'b0);
		send(mk(MODE_CREATE,  32'h0, 8'h01, 32'h0000_0001, 8'h00), 1'b0);
		send(mk(MODE_DEREF,   32'h0000_0100, 8'hFF, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_DEREF,   32'h0000_0100, 8'hFE, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_DEREF,   32'h0000_0200, 8'hFF, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_DEREF,   32'h0000_0140, 8'hFF, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_DEREF,   32'hFFFF_FFFF, 8'hFF, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_DEREF,   32'h0000_0100, 8'h00, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_DESTROY, 32'h0000_0100, 8'h00, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_DESTROY, 32'h0000_0101, 8'h01, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_DESTROY, 32'h0000_0101, 8'h01, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_DEREF,   32'h0000_0101, 8'h01, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_CREATE,  32'h0, 8'h80, 32'h8000_0000, 8'h00), 1'b0);
		send(mk(MODE_DEREF,   32'h0000_0201, 8'h80, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_SWEEP,   32'h0, 8'h00, 32'h0, 8'h55), 1'b0);
		send(mk(MODE_SWEEP,   32'h0, 8'h00, 32'h0, 8'hFF), 1'b0);
		send(mk(MODE_SWEEP,   32'h0, 8'h00, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_SWEEP,   32'h0, 8'h00, 32'h0, 8'h00), 1'b0);
		send(mk(MODE_CREATE,  32'h0, 8'h07, 32'h0000_1234, 8'h00), 1'b0);

		// random traffic, with two full-table episodes
		ep_a = 1'b0;
		ep_b = 1'b0;
		while (issued < ITEMS) begin
			if (!ep_a && issued >= 120) begin
				ep_a = 1'b1;
				fill_episode(8'h00);
			end else if (!ep_b && issued >= 300) begin
				ep_b = 1'b1;
				fill_episode(8'hFF);
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 35) begin
					r = $urandom;
					if (r == 0) r = 1;
					send(mk(MODE_CREATE, $urandom, 8'($urandom_range(1, 255)), r, pick_owner()),
					     $urandom_range(0, 39) == 0);
				end else if (roll < 40) begin
					if ($urandom_range(0, 1))
						send(mk(MODE_CREATE, $urandom, 8'h00, $urandom, 8'($urandom)), 1'b0);
					else
						send(mk(MODE_CREATE, $urandom, 8'($urandom), 32'h0, 8'($urandom)),
						     1'b0);
				end else if (roll < 60) begin
					touch_live(MODE_DEREF);
				end else if (roll < 75) begin
					touch_live(MODE_DESTROY);
				end else if (roll < 82) begin
					send(mk(MODE_SWEEP, $urandom, 8'($urandom), $urandom, pick_owner()),
					     $urandom_range(0, 9) == 0);
				end else begin
					send(mk(mode_t'($urandom_range(0, 3)), $urandom, 8'($urandom), $urandom,
					        8'($urandom)), 1'b0);
				end
			end
		end
		// let the block go quiet once right after the directed part
		cmd_backlog[22].hold = 1'b1;

		// reset, released on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start) @(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (SLOT_COUNT + 8) @(posedge clk);

		$display("%0d requests taken: %0d create, %0d deref, %0d destroy, %0d sweep; %0d results",
		         issued, mode_seen[MODE_CREATE], mode_seen[MODE_DEREF],
		         mode_seen[MODE_DESTROY], mode_seen[MODE_SWEEP], results_checked);
		$display("bad arg %0d, table full %0d, invalid %0d, none released %0d, biggest sweep %0d",
		         status_seen[ST_BAD_ARG], status_seen[ST_FULL], status_seen[ST_INVALID],
		         status_seen[ST_NONE], max_released);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/ght_pkg.sv
src/ght_slot_store.sv
src/generational_handle_table_top.sv
tb/tb_top.sv
